/* design/cde_pkg.sv */
`timescale 1ns / 1ps
package cde_pkg;

  localparam int FIRST_YEAR = 1900;
  // 1900 mod 400, the starting point of the leap cycle counter
  localparam logic [8:0] FIRST_C400 = 9'd300;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_NEXT = 2'd1,
    ACT_PREV = 2'd2,
    ACT_ADD  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_NEXT    = 4'd2,
    CMD_PREV    = 4'd3,
    CMD_INVALID = 4'd4,
    CMD_SYEAR   = 4'd5,
    CMD_SMONTH  = 4'd6,
    CMD_SCOMMIT = 4'd7,
    CMD_RED_UP  = 4'd8,
    CMD_RED_DN  = 4'd9,
    CMD_ASTART  = 4'd10,
    CMD_AYEAR   = 4'd11,
    CMD_AMONTH  = 4'd12,
    CMD_ACOMMIT = 4'd13
  } cmd_t;

  typedef struct packed {
    logic    pre_ok;
    action_t act;
    logic    set_year_more;
    logic    set_month_more;
    logic    add_year_more;
    logic    add_month_more;
    logic    acc_neg;
    logic    acc_high;
    logic    out_free;
  } ctrl_status_t;

  // Leap year from the position of the year within the 400-year cycle
  function automatic logic leap_of(input logic [8:0] c);
    return (c[1:0] == 2'b00) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

/* design/cde_in_if.sv */
`timescale 1ns / 1ps
interface cde_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [11:0]       year_in;
  logic [3:0]        month_in;
  logic [4:0]        day_in;
  logic signed [17:0] offset;

  modport source (output valid, output action, output year_in, output month_in,
                  output day_in, output offset, input ready);
  modport sink (input valid, input action, input year_in, input month_in,
                input day_in, input offset, output ready);
endinterface

/* design/cde_out_if.sv */
`timescale 1ns / 1ps
interface cde_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [16:0] day_number;
  logic        set_valid;

  modport source (output valid, output year_out, output month_out, output day_out,
                  output day_number, output set_valid, input ready);
  modport sink (input valid, input year_out, input month_out, input day_out,
                input day_number, input set_valid, output ready);
endinterface

/* design/cde_controller.sv */
`timescale 1ns / 1ps
module cde_controller import cde_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   in_action,
  output logic         in_ready,
  input  ctrl_status_t status,
  output cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWALK = 5'b00010,
    S_STEP  = 5'b00100,
    S_RED   = 5'b01000,
    S_AWALK = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_LOAD;
          case (action_t'(in_action))
            ACT_SET: state_next = S_SWALK;
            ACT_ADD: state_next = S_RED;
            default: state_next = S_STEP;
          endcase
        end
      end
      S_SWALK: begin
        if (!status.pre_ok) begin
          if (status.out_free) begin
            cmd        = CMD_INVALID;
            state_next = S_IDLE;
          end
        end else if (status.set_year_more) begin
          cmd = CMD_SYEAR;
        end else if (status.set_month_more) begin
          cmd = CMD_SMONTH;
        end else if (status.out_free) begin
          cmd        = CMD_SCOMMIT;
          state_next = S_IDLE;
        end
      end
      S_STEP: begin
        if (status.out_free) begin
          cmd        = (status.act == ACT_PREV) ? CMD_PREV : CMD_NEXT;
          state_next = S_IDLE;
        end
      end
      S_RED: begin
        // bring the sum into the span, one span per cycle
        if (status.acc_neg) begin
          cmd = CMD_RED_UP;
        end else if (status.acc_high) begin
          cmd = CMD_RED_DN;
        end else begin
          cmd        = CMD_ASTART;
          state_next = S_AWALK;
        end
      end
      S_AWALK: begin
        if (status.add_year_more) begin
          cmd = CMD_AYEAR;
        end else if (status.add_month_more) begin
          cmd = CMD_AMONTH;
        end else if (status.out_free) begin
          cmd        = CMD_ACOMMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/cde_datapath.sv */
`timescale 1ns / 1ps
module cde_datapath import cde_pkg::*; #(
  parameter int END_YEAR = 2100
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output ctrl_status_t       status,
  input  logic [1:0]         action,
  input  logic [11:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [17:0] offset,
  cde_out_if.source          result
);

  localparam int LAST_YEAR   = END_YEAR - 1;
  localparam int LEAPS_END   = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400;
  localparam int LEAPS_FIRST = (FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100
                               + (FIRST_YEAR - 1) / 400;
  localparam int SPAN = 365 * (END_YEAR - FIRST_YEAR) + LEAPS_END - LEAPS_FIRST;
  localparam int DW   = $clog2(SPAN);
  localparam int AW   = ((DW > 18) ? DW : 18) + 2;
  localparam logic [8:0] LAST_C400 = 9'(LAST_YEAR % 400);
  localparam logic signed [AW-1:0] SPAN_S = AW'(SPAN);

  // stored date, with its place in the leap cycle and its day number
  logic [11:0]   year;
  logic [3:0]    month;
  logic [4:0]    day;
  logic [8:0]    c400;
  logic [DW-1:0] dnum;

  logic [11:0]   year_next;
  logic [3:0]    month_next;
  logic [4:0]    day_next;
  logic [8:0]    c400_next;
  logic [DW-1:0] dnum_next;
  logic          valid_next;
  logic          commit;

  // latched transaction
  action_t     act_l;
  logic [11:0] y_l;
  logic [3:0]  m_l;
  logic [4:0]  d_l;
  logic        pre_ok;

  // calendar walker
  logic [11:0]            wy;
  logic [8:0]             wc;
  logic [3:0]             wm;
  logic signed [AW-1:0]   acc;
  logic [DW-1:0]          rem;

  logic       wleap;
  logic [8:0] ylen;
  logic [4:0] mlen_w;
  logic [8:0] wc_inc;
  logic       cur_leap;
  logic [4:0] cur_mlen;
  logic [4:0] prev_mlen;
  logic [4:0] in_mlen;
  logic       in_ok;

  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [16:0] out_dnum;
  logic        out_set_valid;

  assign wleap     = leap_of(wc);
  assign ylen      = wleap ? 9'd366 : 9'd365;
  assign mlen_w    = month_days(wm, wleap);
  assign wc_inc    = (wc == 9'd399) ? 9'd0 : wc + 9'd1;
  assign cur_leap  = leap_of(c400);
  assign cur_mlen  = month_days(month, cur_leap);
  assign prev_mlen = month_days(month - 4'd1, cur_leap);

  // Feb 29 passes here; the leap check follows once the year walk is done
  assign in_mlen = month_days(month_in, 1'b1);
  assign in_ok   = (year_in >= 12'(FIRST_YEAR)) && (year_in <= 12'(LAST_YEAR)) &&
                   (day_in != 5'd0) && (day_in <= in_mlen);

  assign status.pre_ok         = pre_ok;
  assign status.act            = act_l;
  assign status.set_year_more  = wy < y_l;
  assign status.set_month_more = wm < m_l;
  assign status.add_year_more  = rem >= DW'(ylen);
  assign status.add_month_more = rem >= DW'(mlen_w);
  assign status.acc_neg        = acc[AW-1];
  assign status.acc_high       = acc >= SPAN_S;
  assign status.out_free       = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        act_l  <= action_t'(action);
        y_l    <= year_in;
        m_l    <= month_in;
        d_l    <= day_in;
        pre_ok <= in_ok;
        wy     <= 12'(FIRST_YEAR);
        wc     <= FIRST_C400;
        wm     <= 4'd1;
        if (action_t'(action) == ACT_ADD) begin
          acc <= $signed(AW'(dnum)) + AW'(offset);
        end else begin
          acc <= '0;
        end
      end
      CMD_RED_UP: acc <= acc + SPAN_S;
      CMD_RED_DN: acc <= acc - SPAN_S;
      CMD_ASTART: rem <= acc[DW-1:0];
      CMD_SYEAR: begin
        acc <= acc + AW'(ylen);
        wy  <= wy + 12'd1;
        wc  <= wc_inc;
      end
      CMD_SMONTH: begin
        acc <= acc + AW'(mlen_w);
        wm  <= wm + 4'd1;
      end
      CMD_AYEAR: begin
        rem <= rem - DW'(ylen);
        wy  <= wy + 12'd1;
        wc  <= wc_inc;
      end
      CMD_AMONTH: begin
        rem <= rem - DW'(mlen_w);
        wm  <= wm + 4'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    c400_next  = c400;
    dnum_next  = dnum;
    valid_next = 1'b0;
    commit     = 1'b0;
    case (cmd)
      CMD_NEXT: begin
        commit = 1'b1;
        if (day < cur_mlen) begin
          day_next  = day + 5'd1;
          dnum_next = dnum + DW'(1);
        end else begin
          day_next = 5'd1;
          if (month < 4'd12) begin
            month_next = month + 4'd1;
            dnum_next  = dnum + DW'(1);
          end else begin
            month_next = 4'd1;
            if (year == 12'(LAST_YEAR)) begin
              // wrap to the start of the span
              year_next = 12'(FIRST_YEAR);
              c400_next = FIRST_C400;
              dnum_next = '0;
            end else begin
              year_next = year + 12'd1;
              c400_next = (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
              dnum_next = dnum + DW'(1);
            end
          end
        end
      end
      CMD_PREV: begin
        commit = 1'b1;
        if (day > 5'd1) begin
          day_next  = day - 5'd1;
          dnum_next = dnum - DW'(1);
        end else if (month > 4'd1) begin
          month_next = month - 4'd1;
          day_next   = prev_mlen;
          dnum_next  = dnum - DW'(1);
        end else begin
          month_next = 4'd12;
          day_next   = 5'd31;
          if (year == 12'(FIRST_YEAR)) begin
            // wrap to the last day of the span
            year_next = 12'(LAST_YEAR);
            c400_next = LAST_C400;
            dnum_next = DW'(SPAN - 1);
          end else begin
            year_next = year - 12'd1;
            c400_next = (c400 == 9'd0) ? 9'd399 : c400 - 9'd1;
            dnum_next = dnum - DW'(1);
          end
        end
      end
      CMD_INVALID: begin
        commit     = 1'b1;
        year_next  = 12'(FIRST_YEAR);
        month_next = 4'd1;
        day_next   = 5'd1;
        c400_next  = FIRST_C400;
        dnum_next  = '0;
      end
      CMD_SCOMMIT: begin
        commit = 1'b1;
        if ((m_l == 4'd2) && (d_l == 5'd29) && !wleap) begin
          year_next  = 12'(FIRST_YEAR);
          month_next = 4'd1;
          day_next   = 5'd1;
          c400_next  = FIRST_C400;
          dnum_next  = '0;
        end else begin
          year_next  = y_l;
          month_next = m_l;
          day_next   = d_l;
          c400_next  = wc;
          dnum_next  = acc[DW-1:0] + DW'(d_l) - DW'(1);
          valid_next = 1'b1;
        end
      end
      CMD_ACOMMIT: begin
        commit     = 1'b1;
        year_next  = wy;
        month_next = wm;
        day_next   = rem[4:0] + 5'd1;
        c400_next  = wc;
        dnum_next  = acc[DW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= 12'(FIRST_YEAR);
      month <= 4'd1;
      day   <= 5'd1;
      c400  <= FIRST_C400;
      dnum  <= '0;
    end else if (commit) begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
      c400  <= c400_next;
      dnum  <= dnum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_year      <= year_next;
      out_month     <= month_next;
      out_day       <= day_next;
      out_dnum      <= 17'(dnum_next);
      out_set_valid <= valid_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.year_out   = out_year;
  assign result.month_out  = out_month;
  assign result.day_out    = out_day;
  assign result.day_number = out_dnum;
  assign result.set_valid  = out_set_valid;

`ifndef SYNTHESIS
  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || result.ready))
    else $error("result register overwritten before transaction completed");

  a_date_in_span: assert property (@(posedge clk) disable iff (rst)
    (year >= 12'(FIRST_YEAR)) && (year <= 12'(LAST_YEAR)) && (month >= 4'd1) &&
    (month <= 4'd12) && (day >= 5'd1) && (day <= cur_mlen))
    else $error("stored date left the calendar span");

  a_dnum_in_span: assert property (@(posedge clk) disable iff (rst)
    dnum < SPAN)
    else $error("day number beyond span");

  a_reduced_sum: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_ASTART) |-> (!acc[AW-1] && (acc < SPAN_S)))
    else $error("add walk started on an unreduced day number");

  a_add_walk_end: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_ACOMMIT) |-> ((wm >= 4'd1) && (wm <= 4'd12) && (rem < DW'(mlen_w))))
    else $error("add walk ended outside its month");
`endif

endmodule

/* design/calendar_date_engine_unit.sv */
`timescale 1ns / 1ps
// Gregorian date engine holding one date between 1900-01-01 and the last day of
// END_YEAR-1, with its day number since 1900-01-01. Each request transaction sets
// the date (an invalid date loads 1900-01-01 with set_valid low), steps one day
// forward or back with wrap at the ends of the span, or adds a signed offset modulo
// the span; every request gives exactly one result. One request is in work at a
// time and the next is taken in the cycle after the previous result is written to
// the output register, which holds it until taken. For a set, a leap-cycle
// counter walks the years and then the months one per cycle; a set whose year,
// month or day is out of range is caught at once, but Feb 29 of a common year is
// caught only after the walk. An add first brings the day-number sum into the
// span, one span correction per cycle, then walks whole years and whole months
// from 1900 to the target date. A result still waiting in the output register
// holds back only the final write.
module calendar_date_engine_unit import cde_pkg::*; #(
  parameter int END_YEAR = 2100
) (
  input  logic      clk,
  input  logic      rst,
  cde_in_if.sink    request,
  cde_out_if.source result
);

  logic         in_ready;
  cmd_t         cmd;
  ctrl_status_t status;

  assign request.ready = in_ready;

  cde_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_action (request.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cde_datapath #(
    .END_YEAR (END_YEAR)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .action   (request.action),
    .year_in  (request.year_in),
    .month_in (request.month_in),
    .day_in   (request.day_in),
    .offset   (request.offset),
    .result   (result)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import cde_pkg::*;

  localparam int END_YEAR     = 2100;
  localparam int RANDOM_ITEMS = 1525;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_WAIT  = 300;
  localparam int DRAIN_LIMIT  = 200000;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] number;
    logic        set_valid;
  } date_result_t;

  typedef struct packed {
    action_t            act;
    logic [11:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [17:0] offset;
    logic               typed;
    date_result_t       want;
  } date_request_t;

  logic clk;
  logic rst;

  cde_in_if  request_ch ();
  cde_out_if result_ch ();

  calendar_date_engine_unit #(.END_YEAR(END_YEAR)) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted calendar state
  int cal_year  = FIRST_YEAR;
  int cal_month = 1;
  int cal_day   = 1;

  date_result_t  expected_dates[$];
  date_request_t directed_rows[$];

  int failures       = 0;
  int results_seen   = 0;
  int burst_left     = 0;
  int rejected_sets  = 0;
  int action_count[4];

  function automatic bit is_leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(input int y, input int m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int year_length(input int y);
    return 365 + int'(is_leap_year(y));
  endfunction

  function automatic int span_length();
    int n;
    n = 0;
    for (int y = FIRST_YEAR; y < END_YEAR; y++) n += year_length(y);
    return n;
  endfunction

  function automatic int index_of_date(input int y, input int m, input int d);
    int n;
    n = d - 1;
    for (int i = 1; i < m; i++) n += month_length(y, i);
    for (int i = FIRST_YEAR; i < y; i++) n += year_length(i);
    return n;
  endfunction

  function automatic date_result_t step_calendar(input date_request_t rq);
    date_result_t res;
    int y, m, d, n, span;
    bit ok;
    y = int'(rq.year);
    m = int'(rq.month);
    d = int'(rq.day);
    ok = 1'b0;
    case (rq.act)
      ACT_SET: begin
        ok = (y >= FIRST_YEAR) && (y < END_YEAR) && (m >= 1) && (m <= 12) &&
             (d >= 1) && (d <= month_length(y, m));
        if (ok) begin
          cal_year  = y;
          cal_month = m;
          cal_day   = d;
        end else begin
          cal_year  = FIRST_YEAR;
          cal_month = 1;
          cal_day   = 1;
        end
      end
      ACT_NEXT: begin
        cal_day++;
        if (cal_day > month_length(cal_year, cal_month)) begin
          cal_day = 1;
          cal_month++;
          if (cal_month == 13) begin
            cal_month = 1;
            cal_year++;
            if (cal_year >= END_YEAR) cal_year = FIRST_YEAR;
          end
        end
      end
      ACT_PREV: begin
        cal_day--;
        if (cal_day == 0) begin
          cal_month--;
          if (cal_month == 0) begin
            cal_month = 12;
            if (cal_year <= FIRST_YEAR) cal_year = END_YEAR - 1;
            else cal_year--;
          end
          cal_day = month_length(cal_year, cal_month);
        end
      end
      ACT_ADD: begin
        span = span_length();
        n = (index_of_date(cal_year, cal_month, cal_day) + int'($signed(rq.offset))) % span;
        if (n < 0) n += span;
        // walk back out from the start of the span
        cal_year  = FIRST_YEAR;
        cal_month = 1;
        while (n >= year_length(cal_year)) begin
          n -= year_length(cal_year);
          cal_year++;
        end
        while (n >= month_length(cal_year, cal_month)) begin
          n -= month_length(cal_year, cal_month);
          cal_month++;
        end
        cal_day = n + 1;
      end
      default: begin
      end
    endcase
    res.year      = 12'(cal_year);
    res.month     = 4'(cal_month);
    res.day       = 5'(cal_day);
    res.number    = 17'(index_of_date(cal_year, cal_month, cal_day));
    res.set_valid = ok;
    return res;
  endfunction

  function automatic date_result_t make_date(input int y, input int m, input int d,
                                             input int n, input int sv);
    date_result_t r;
    r.year      = 12'(y);
    r.month     = 4'(m);
    r.day       = 5'(d);
    r.number    = 17'(n);
    r.set_valid = 1'(sv);
    return r;
  endfunction

  task automatic directed_row(input action_t act, input int y, input int m, input int d,
                              input int off, input int typed, input date_result_t want);
    date_request_t rq;
    rq.act    = act;
    rq.year   = 12'(y);
    rq.month  = 4'(m);
    rq.day    = 5'(d);
    rq.offset = 18'(off);
    rq.typed  = 1'(typed);
    rq.want   = want;
    directed_rows.push_back(rq);
  endtask

  function automatic date_request_t random_request();
    date_request_t rq;
    int r, s, len, e;
    rq.year   = 12'($urandom);
    rq.month  = 4'($urandom);
    rq.day    = 5'($urandom);
    rq.offset = 18'($urandom);
    rq.typed  = 1'b0;
    rq.want   = '0;
    r = $urandom_range(0, 99);
    if (r < 32) begin
      rq.act = ACT_SET;
      s = $urandom_range(0, 99);
      if (s < 70) begin
        // bias towards month and year ends so that following steps cross them
        case ($urandom_range(0, 3))
          0:       rq.year = 12'($urandom_range(FIRST_YEAR, FIRST_YEAR + 3));
          1:       rq.year = 12'($urandom_range(END_YEAR - 4, END_YEAR - 1));
          default: rq.year = 12'($urandom_range(FIRST_YEAR, END_YEAR - 1));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2: rq.month = 4'd12;
          3, 4:    rq.month = 4'd1;
          5:       rq.month = 4'd2;
          default: rq.month = 4'($urandom_range(1, 12));
        endcase
        len = month_length(int'(rq.year), int'(rq.month));
        case ($urandom_range(0, 3))
          0, 1:    rq.day = 5'(len);
          2:       rq.day = 5'd1;
          default: rq.day = 5'($urandom_range(1, len));
        endcase
      end else if (s < 85) begin
        rq.year  = 12'($urandom_range(FIRST_YEAR, END_YEAR - 1));
        rq.month = 4'($urandom_range(1, 12));
        len = month_length(int'(rq.year), int'(rq.month));
        rq.day = 5'($urandom_range(1, len));
        case ($urandom_range(0, 3))
          0: rq.year = 12'($urandom_range(0, 1) ? $urandom_range(0, FIRST_YEAR - 1)
                                                : $urandom_range(END_YEAR, 4095));
          1: rq.month = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
          2: rq.day = 5'd0;
          default: rq.day = 5'((len < 31) ? $urandom_range(len + 1, 31) : 0);
        endcase
      end
    end else if (r < 55) begin
      rq.act = ACT_NEXT;
    end else if (r < 78) begin
      rq.act = ACT_PREV;
    end else begin
      rq.act = ACT_ADD;
      s = $urandom_range(0, 99);
      if (s >= 40 && s < 75) begin
        rq.offset = 18'(int'($urandom_range(0, 800)) - 400);
      end else if (s >= 75) begin
        e = span_length() + int'($urandom_range(0, 4)) - 2;
        rq.offset = 18'($urandom_range(0, 1) ? -e : e);
      end
    end
    return rq;
  endfunction

  task automatic send_request(input date_request_t rq);
    date_result_t got;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        request_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    request_ch.valid    <= 1'b1;
    request_ch.action   <= rq.act;
    request_ch.year_in  <= rq.year;
    request_ch.month_in <= rq.month;
    request_ch.day_in   <= rq.day;
    request_ch.offset   <= rq.offset;
    do @(posedge clk); while (!request_ch.ready);
    got = step_calendar(rq);
    action_count[rq.act]++;
    if (rq.act == ACT_SET && !got.set_valid) rejected_sets++;
    expected_dates.push_back(rq.typed ? rq.want : got);
  endtask

  // Hold off the sender until every outstanding transaction has returned or the guard runs out
  task automatic drain_results();
    int guard;
    guard = 0;
    request_ch.valid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (expected_dates.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  task automatic note_failure(input string what, input date_result_t want,
                              input date_result_t got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%s at %0t: expected %0d-%0d-%0d #%0d set_valid %0b, %s",
               what, $realtime, want.year, want.month, want.day, want.number,
               want.set_valid,
               $sformatf("got %0d-%0d-%0d #%0d set_valid %0b",
                         got.year, got.month, got.day, got.number, got.set_valid));
  endtask

  // Receiver: change stall pattern whenever the low byte of the cycle counter is zero
  logic [15:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = '0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    result_ch.ready <= 1'b1;
      2'd1:    result_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    result_ch.ready <= (rx_cycle[3:0] < 4'd11);
      default: result_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    date_result_t got;
    date_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.year      = result_ch.year_out;
      got.month     = result_ch.month_out;
      got.day       = result_ch.day_out;
      got.number    = result_ch.day_number;
      got.set_valid = result_ch.set_valid;
      results_seen++;
      if (expected_dates.size() == 0) begin
        note_failure("Unexpected result", '0, got);
      end else begin
        want = expected_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.number !== want.number || got.set_valid !== want.set_valid)
          note_failure("Mismatch", want, got);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    date_result_t none;
    none = '0;
    foreach (action_count[i]) action_count[i] = 0;
    rst                 <= 1'b1;
    request_ch.valid    <= 1'b0;
    request_ch.action   <= ACT_SET;
    request_ch.year_in  <= '0;
    request_ch.month_in <= '0;
    request_ch.day_in   <= '0;
    request_ch.offset   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed_row(ACT_NEXT, 0, 0, 0, 0, 1, make_date(1900, 1, 2, 1, 0));
    directed_row(ACT_PREV, 0, 0, 0, 0, 1, make_date(1900, 1, 1, 0, 0));
    // wrap both ways across the ends of the span
    directed_row(ACT_PREV, 0, 0, 0, 0, 1, make_date(2099, 12, 31, 73048, 0));
    directed_row(ACT_NEXT, 0, 0, 0, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 2099, 12, 31, 0, 1, make_date(2099, 12, 31, 73048, 1));
    directed_row(ACT_NEXT, 4095, 15, 31, -1, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 2100, 1, 1, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1899, 12, 31, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1900, 0, 1, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1900, 13, 1, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1900, 2, 29, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 2004, 2, 30, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1900, 1, 0, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1900, 4, 31, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 4095, 15, 31, 0, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 1900, 1, 1, 0, 1, make_date(1900, 1, 1, 0, 1));
    directed_row(ACT_ADD, 0, 0, 0, -1, 1, make_date(2099, 12, 31, 73048, 0));
    directed_row(ACT_ADD, 0, 0, 0, 1, 1, make_date(1900, 1, 1, 0, 0));
    directed_row(ACT_SET, 2000, 2, 29, 0, 0, none);
    directed_row(ACT_NEXT, 0, 0, 0, 0, 0, none);
    directed_row(ACT_PREV, 0, 0, 0, 0, 0, none);
    directed_row(ACT_ADD, 0, 0, 0, 131071, 0, none);
    directed_row(ACT_ADD, 0, 0, 0, -131072, 0, none);
    directed_row(ACT_ADD, 0, 0, 0, 73049, 0, none);
    directed_row(ACT_SET, 1996, 12, 31, 0, 0, none);
    directed_row(ACT_NEXT, 0, 0, 0, 0, 0, none);
    directed_row(ACT_ADD, 0, 0, 0, 0, 0, none);

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_request(random_request());
    end

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    while (expected_dates.size() != 0)
      note_failure("Missing result", expected_dates.pop_front(), '0);

    $display("Ran %0d transactions: %0d set (%0d rejected), %0d next, %0d previous, %0d add",
             action_count[ACT_SET] + action_count[ACT_NEXT] + action_count[ACT_PREV] +
             action_count[ACT_ADD], action_count[ACT_SET], rejected_sets,
             action_count[ACT_NEXT], action_count[ACT_PREV], action_count[ACT_ADD]);
    $display("Compared %0d results, %0d failures", results_seen, failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
